### rtl/assert_macros.svh
// Assertion macros used by the RTL of the log field splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/wlfs_pkg.sv
// Types, codes and format scripts of the web log line field splitter.
`default_nettype none

package wlfs_pkg;

  localparam int STEP_W = 5;
  localparam int SKIP_W = 2;

  // Log formats selected by the configuration register.
  localparam logic [1:0] FMT_COMMON   = 2'd0;
  localparam logic [1:0] FMT_COMBINED = 2'd1;
  localparam logic [1:0] FMT_ERROR    = 2'd2;

  // Script step kinds.
  localparam logic [1:0] K_COLLECT = 2'd0;
  localparam logic [1:0] K_SKIP    = 2'd1;
  localparam logic [1:0] K_REST    = 2'd2;
  localparam logic [1:0] K_DONE    = 2'd3;

  // Delimiters.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_T      = 8'h74;

  // Field identifiers.
  localparam logic [3:0] FID_NONE    = 4'd0;
  localparam logic [3:0] FID_HOST    = 4'd1;
  localparam logic [3:0] FID_IDENT   = 4'd2;
  localparam logic [3:0] FID_USER    = 4'd3;
  localparam logic [3:0] FID_DATE    = 4'd4;
  localparam logic [3:0] FID_METHOD  = 4'd5;
  localparam logic [3:0] FID_PATH    = 4'd6;
  localparam logic [3:0] FID_VERSION = 4'd7;
  localparam logic [3:0] FID_STATUS  = 4'd8;
  localparam logic [3:0] FID_BYTES   = 4'd9;
  localparam logic [3:0] FID_REFERER = 4'd10;
  localparam logic [3:0] FID_AGENT   = 4'd11;
  localparam logic [3:0] FID_MODULE  = 4'd12;
  localparam logic [3:0] FID_PROCESS = 4'd13;
  localparam logic [3:0] FID_CLIENT  = 4'd14;
  localparam logic [3:0] FID_MESSAGE = 4'd15;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] arg;
    logic [3:0] fid;
  } step_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [SKIP_W-1:0] skip;
    logic              err;
  } parse_state_t;

  typedef struct packed {
    logic [3:0] field_id;
    logic       in_field;
    logic       field_end;
    logic       parse_error;
    logic       line_done;
    logic       line_ok;
  } result_t;

  function automatic step_t mk_step(input logic [1:0] kind, input logic [7:0] arg,
                                    input logic [3:0] fid);
    step_t s;
    s.valid = 1'b1;
    s.kind  = kind;
    s.arg   = arg;
    s.fid   = fid;
    return s;
  endfunction

  // Script entry for a format and step; steps past the script read as invalid.
  function automatic step_t get_step(input logic [1:0] fmt, input logic [STEP_W-1:0] st);
    step_t s;
    s = '{valid: 1'b0, kind: K_DONE, arg: 8'h00, fid: FID_NONE};
    case (fmt)
      FMT_COMMON, FMT_COMBINED: begin
        case (st)
          5'd0:  s = mk_step(K_COLLECT, CH_SPACE, FID_HOST);
          5'd1:  s = mk_step(K_COLLECT, CH_SPACE, FID_IDENT);
          5'd2:  s = mk_step(K_COLLECT, CH_SPACE, FID_USER);
          5'd3:  s = mk_step(K_SKIP, 8'd1, FID_NONE);
          5'd4:  s = mk_step(K_COLLECT, CH_RBRACK, FID_DATE);
          5'd5:  s = mk_step(K_SKIP, 8'd2, FID_NONE);
          5'd6:  s = mk_step(K_COLLECT, CH_SPACE, FID_METHOD);
          5'd7:  s = mk_step(K_COLLECT, CH_SPACE, FID_PATH);
          5'd8:  s = mk_step(K_COLLECT, CH_QUOTE, FID_VERSION);
          5'd9:  s = mk_step(K_SKIP, 8'd1, FID_NONE);
          5'd10: s = mk_step(K_COLLECT, CH_SPACE, FID_STATUS);
          default: begin
            if (fmt == FMT_COMMON) begin
              if (st == 5'd11) s = mk_step(K_REST, 8'd0, FID_BYTES);
            end else begin
              case (st)
                5'd11: s = mk_step(K_COLLECT, CH_SPACE, FID_BYTES);
                5'd12: s = mk_step(K_SKIP, 8'd1, FID_NONE);
                5'd13: s = mk_step(K_COLLECT, CH_QUOTE, FID_REFERER);
                5'd14: s = mk_step(K_SKIP, 8'd2, FID_NONE);
                5'd15: s = mk_step(K_COLLECT, CH_QUOTE, FID_AGENT);
                5'd16: s = mk_step(K_DONE, 8'd0, FID_NONE);
                default: ;
              endcase
            end
          end
        endcase
      end
      FMT_ERROR: begin
        case (st)
          5'd0:  s = mk_step(K_SKIP, 8'd1, FID_NONE);
          5'd1:  s = mk_step(K_COLLECT, CH_RBRACK, FID_DATE);
          5'd2:  s = mk_step(K_SKIP, 8'd2, FID_NONE);
          5'd3:  s = mk_step(K_COLLECT, CH_RBRACK, FID_MODULE);
          5'd4:  s = mk_step(K_SKIP, 8'd2, FID_NONE);
          5'd5:  s = mk_step(K_COLLECT, CH_RBRACK, FID_PROCESS);
          5'd6:  s = mk_step(K_COLLECT, CH_T, FID_NONE);
          5'd7:  s = mk_step(K_SKIP, 8'd1, FID_NONE);
          5'd8:  s = mk_step(K_COLLECT, CH_RBRACK, FID_CLIENT);
          5'd9:  s = mk_step(K_SKIP, 8'd1, FID_NONE);
          5'd10: s = mk_step(K_REST, 8'd0, FID_MESSAGE);
          default: ;
        endcase
      end
      default: ;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/wlfs_step.sv
// Per-character script step: result and next parser state for one character.
`default_nettype none

module wlfs_step (
  input  wire logic [1:0]           fmt,
  input  wire wlfs_pkg::parse_state_t state_cur,
  input  wire logic [7:0]           char_byte,
  input  wire logic                 last,
  output      wlfs_pkg::parse_state_t state_nxt,
  output      wlfs_pkg::result_t    res
);
  import wlfs_pkg::*;

  step_t                 cur_step;
  step_t                 new_step;
  logic                  err_in;
  logic                  accepting;
  logic                  perr;
  logic [STEP_W-1:0]     step_adv;
  logic [SKIP_W-1:0]     skip_adv;
  logic [3:0]            fid;
  logic                  inf;
  logic                  fend;

  always_comb begin
    cur_step = get_step(fmt, state_cur.step);
    err_in   = state_cur.err | ~cur_step.valid;
    step_adv = state_cur.step;
    skip_adv = state_cur.skip;
    fid      = FID_NONE;
    inf      = 1'b0;
    fend     = 1'b0;
    if (!err_in) begin
      case (cur_step.kind)
        K_SKIP: begin
          if (({1'b0, state_cur.skip} + 3'd1) >= cur_step.arg[2:0]) begin
            step_adv = state_cur.step + STEP_W'(1);
            skip_adv = '0;
          end else begin
            skip_adv = state_cur.skip + SKIP_W'(1);
          end
        end
        K_COLLECT: begin
          fid = cur_step.fid;
          if (char_byte == cur_step.arg) begin
            fend     = (cur_step.fid != FID_NONE);
            step_adv = state_cur.step + STEP_W'(1);
          end else begin
            inf = (cur_step.fid != FID_NONE);
          end
        end
        K_REST: begin
          fid = cur_step.fid;
          inf = 1'b1;
        end
        default: ;
      endcase
    end

    // The accepting check looks at the step the script stands on after this character.
    new_step  = get_step(fmt, step_adv);
    accepting = ~err_in & new_step.valid &
                ((new_step.kind == K_REST) | (new_step.kind == K_DONE));
    perr      = err_in | (last & ~accepting);

    res.field_id    = fid;
    res.in_field    = inf;
    res.field_end   = fend;
    res.parse_error = perr;
    res.line_done   = last;
    res.line_ok     = last & ~perr;

    if (last) begin
      state_nxt = '0;
    end else begin
      state_nxt.step = step_adv;
      state_nxt.skip = skip_adv;
      state_nxt.err  = perr;
    end
  end

endmodule

`default_nettype wire

### rtl/web_log_line_field_splitter_core.sv
// Top level of the web log line field splitter.
// Usage:
//   The input channel carries one character of a log line per transaction,
//   with in_last marking the final character. Each input transaction yields
//   exactly one result transaction naming the field the character belongs to,
//   its content/end role, and the line status on the last character.
//   cfg_wr_en with cfg_wr_data selects the format (common, combined, error);
//   write it only while no line is in flight.
//   An accepted character's result is registered in the output or skid register.
//   Throughput is one character per cycle while in_stall is low: the script
//   step is a small table lookup and state update done in the accepting cycle.
//   The result side has an output register plus a one-entry skid register, so
//   in_stall is a register output and rises only once both hold a result.
//   When the receiver stalls, the output payload holds until taken.
//   Reset (synchronous, active low) selects the common format, restarts the
//   script at its first step, clears the error flag and empties both registers.
`default_nettype none

module web_log_line_field_splitter_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_wr_data,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_last,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [3:0] out_field_id,
  output      logic       out_in_field,
  output      logic       out_field_end,
  output      logic       out_parse_error,
  output      logic       out_line_done,
  output      logic       out_line_ok
);
  import wlfs_pkg::*;
  `include "assert_macros.svh"

  logic [1:0]   fmt_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  result_t      step_res;
  result_t      out_res_r;
  result_t      skid_res_r;
  logic         out_v_r;
  logic         out_v_nxt;
  logic         skid_v_r;
  logic         skid_v_nxt;
  logic         in_acc;
  logic         out_take;

  assign in_acc   = in_valid & ~skid_v_r;
  assign out_take = out_v_r & ~out_stall;

  wlfs_step u_step (
    .fmt       (fmt_r),
    .state_cur (state_r),
    .char_byte (in_char_byte),
    .last      (in_last),
    .state_nxt (state_nxt),
    .res       (step_res)
  );

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (out_take) skid_v_nxt = 1'b0;
    end else if (in_acc) begin
      if (out_v_r && !out_take) skid_v_nxt = 1'b1;
      else out_v_nxt = 1'b1;
    end else if (out_take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_COMMON;
      state_r  <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) fmt_r <= cfg_wr_data;
      if (in_acc) state_r <= state_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Payload registers: a result goes to the skid register only when the
  // output register is occupied and not being taken this cycle.
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) out_res_r <= skid_res_r;
    end else if (in_acc) begin
      if (out_v_r && !out_take) skid_res_r <= step_res;
      else out_res_r <= step_res;
    end
  end

  assign in_stall        = skid_v_r;
  assign out_valid       = out_v_r;
  assign out_field_id    = out_res_r.field_id;
  assign out_in_field    = out_res_r.in_field;
  assign out_field_end   = out_res_r.field_end;
  assign out_parse_error = out_res_r.parse_error;
  assign out_line_done   = out_res_r.line_done;
  assign out_line_ok     = out_res_r.line_ok;

  `ASSERT_CLK(a_skid_needs_out, skid_v_r |-> out_v_r, "skid entry without output entry")
  `ASSERT_CLK(a_line_restart, (in_acc && in_last) |=> (state_r == '0), "script not restarted")
  `ASSERT_CLK(a_ok_excl_err, (out_v_r && out_line_ok) |-> (out_line_done && !out_parse_error), "line ok conflicts with status")
  `ASSERT_CLK(a_field_roles, out_v_r |-> !(out_in_field && out_field_end), "content and end both set")

endmodule

`default_nettype wire

### tb/web_log_line_field_splitter_checker.sv
// Checker for the log field splitter: predicts a field tag per character and compares results.
`timescale 1ns / 100ps

module web_log_line_field_splitter_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_wr_data,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_last,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [3:0] out_field_id,
  input  wire logic       out_in_field,
  input  wire logic       out_field_end,
  input  wire logic       out_parse_error,
  input  wire logic       out_line_done,
  input  wire logic       out_line_ok,
  output int              tag_errors,
  output int              tags_due
);
  import wlfs_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] arg;
    logic [3:0] fid;
  } script_op_t;

  logic [1:0]          log_fmt;
  logic [STEP_W-1:0]   cur_step;
  logic [SKIP_W-1:0]   skip_cnt;
  logic                line_err;
  result_t             char_tags_due[$];
  result_t             got_tag;
  result_t             want_tag;

  function automatic int script_len(input logic [1:0] fmt);
    case (fmt)
      FMT_COMMON:   return 12;
      FMT_COMBINED: return 17;
      FMT_ERROR:    return 11;
      default:      return 0;
    endcase
  endfunction

  // Entry of the format's script at one step; only called for steps inside the script.
  function automatic script_op_t script_op(input logic [1:0] fmt, input logic [STEP_W-1:0] idx);
    script_op_t op;
    op = '{K_DONE, 8'h00, FID_NONE};
    if (fmt == FMT_ERROR) begin
      case (idx)
        5'd0, 5'd7, 5'd9: op = '{K_SKIP, 8'd1, FID_NONE};
        5'd2, 5'd4:       op = '{K_SKIP, 8'd2, FID_NONE};
        5'd1:             op = '{K_COLLECT, CH_RBRACK, FID_DATE};
        5'd3:             op = '{K_COLLECT, CH_RBRACK, FID_MODULE};
        5'd5:             op = '{K_COLLECT, CH_RBRACK, FID_PROCESS};
        5'd6:             op = '{K_COLLECT, CH_T, FID_NONE};
        5'd8:             op = '{K_COLLECT, CH_RBRACK, FID_CLIENT};
        5'd10:            op = '{K_REST, 8'h00, FID_MESSAGE};
        default: ;
      endcase
    end else begin
      case (idx)
        5'd0:              op = '{K_COLLECT, CH_SPACE, FID_HOST};
        5'd1:              op = '{K_COLLECT, CH_SPACE, FID_IDENT};
        5'd2:              op = '{K_COLLECT, CH_SPACE, FID_USER};
        5'd3, 5'd9, 5'd12: op = '{K_SKIP, 8'd1, FID_NONE};
        5'd4:              op = '{K_COLLECT, CH_RBRACK, FID_DATE};
        5'd5, 5'd14:       op = '{K_SKIP, 8'd2, FID_NONE};
        5'd6:              op = '{K_COLLECT, CH_SPACE, FID_METHOD};
        5'd7:              op = '{K_COLLECT, CH_SPACE, FID_PATH};
        5'd8:              op = '{K_COLLECT, CH_QUOTE, FID_VERSION};
        5'd10:             op = '{K_COLLECT, CH_SPACE, FID_STATUS};
        5'd11: begin
          if (fmt == FMT_COMMON) op = '{K_REST, 8'h00, FID_BYTES};
          else op = '{K_COLLECT, CH_SPACE, FID_BYTES};
        end
        5'd13:             op = '{K_COLLECT, CH_QUOTE, FID_REFERER};
        5'd15:             op = '{K_COLLECT, CH_QUOTE, FID_AGENT};
        default: ;
      endcase
    end
    return op;
  endfunction

  // Advances the parse state by one character and returns the tag it earns.
  function automatic result_t tag_char(input logic [7:0] ch, input logic lst);
    script_op_t op;
    result_t    r;
    logic       accepting;
    r = '0;
    accepting = 1'b0;
    // A format change can leave the step outside the new script.
    if (!line_err && int'(cur_step) >= script_len(log_fmt)) line_err = 1'b1;
    if (!line_err) begin
      op = script_op(log_fmt, cur_step);
      case (op.kind)
        K_SKIP: begin
          if (int'(skip_cnt) + 1 >= int'(op.arg)) begin
            cur_step = cur_step + STEP_W'(1);
            skip_cnt = '0;
          end else begin
            skip_cnt = skip_cnt + SKIP_W'(1);
          end
        end
        K_COLLECT: begin
          r.field_id = op.fid;
          if (ch == op.arg) begin
            r.field_end = (op.fid != FID_NONE);
            cur_step = cur_step + STEP_W'(1);
          end else begin
            r.in_field = (op.fid != FID_NONE);
          end
        end
        K_REST: begin
          r.field_id = op.fid;
          r.in_field = 1'b1;
        end
        default: ;
      endcase
      if (int'(cur_step) < script_len(log_fmt)) begin
        op = script_op(log_fmt, cur_step);
        accepting = (op.kind == K_REST) || (op.kind == K_DONE);
      end
    end
    r.parse_error = line_err || (lst && !accepting);
    r.line_done   = lst;
    r.line_ok     = lst && !r.parse_error;
    if (lst) begin
      cur_step = '0;
      skip_cnt = '0;
      line_err = 1'b0;
    end else if (r.parse_error) begin
      line_err = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      tag_errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      log_fmt  = FMT_COMMON;
      cur_step = '0;
      skip_cnt = '0;
      line_err = 1'b0;
      char_tags_due.delete();
    end else begin
      if (cfg_wr_en) log_fmt = cfg_wr_data;
      if (in_valid && !in_stall) char_tags_due.push_back(tag_char(in_char_byte, in_last));
      if (out_valid && !out_stall) begin
        got_tag = '{out_field_id, out_in_field, out_field_end, out_parse_error,
                    out_line_done, out_line_ok};
        if (char_tags_due.size() == 0) begin
          tag_errors++;
          $display("%0t: result transaction with none expected, expected none, got %h",
                   $time, got_tag);
        end else begin
          want_tag = char_tags_due.pop_front();
          check_field("field_id", int'(want_tag.field_id), int'(got_tag.field_id));
          check_field("in_field", int'(want_tag.in_field), int'(got_tag.in_field));
          check_field("field_end", int'(want_tag.field_end), int'(got_tag.field_end));
          check_field("parse_error", int'(want_tag.parse_error),
                      int'(got_tag.parse_error));
          check_field("line_done", int'(want_tag.line_done), int'(got_tag.line_done));
          check_field("line_ok", int'(want_tag.line_ok), int'(got_tag.line_ok));
        end
      end
    end
    tags_due = char_tags_due.size();
  end

endmodule

### tb/web_log_line_field_splitter_core_tb.sv
// Testbench top for the log field splitter: clock, reset, log line stimulus and verdict.
`timescale 1ns / 100ps

module web_log_line_field_splitter_core_tb;
  import wlfs_pkg::*;

  localparam logic [1:0] FMT_UNKNOWN  = 2'd3;
  localparam int         RANDOM_ITEMS = 2000;
  localparam int         STUCK_LIMIT  = 2000;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_field_id;
  logic       out_in_field;
  logic       out_field_end;
  logic       out_parse_error;
  logic       out_line_done;
  logic       out_line_ok;

  int         tag_errors;
  int         tags_due;

  logic [7:0] line_q[$];
  logic [1:0] cur_fmt;
  int         burst_left;
  int         items_sent;
  int         stuck_cycles = 0;
  int         stall_span = 0;
  logic [1:0] stall_mode = 2'd0;

  web_log_line_field_splitter_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_byte    (in_char_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_id    (out_field_id),
    .out_in_field    (out_in_field),
    .out_field_end   (out_field_end),
    .out_parse_error (out_parse_error),
    .out_line_done   (out_line_done),
    .out_line_ok     (out_line_ok)
  );

  web_log_line_field_splitter_checker tag_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_byte    (in_char_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_id    (out_field_id),
    .out_in_field    (out_in_field),
    .out_field_end   (out_field_end),
    .out_parse_error (out_parse_error),
    .out_line_done   (out_line_done),
    .out_line_ok     (out_line_ok),
    .tag_errors      (tag_errors),
    .tags_due        (tags_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver switches at random between stall patterns: none, sparse, periodic and mostly stalled.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= (stall_span % 3 == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("web_log_line_field_splitter_core verification failed");
      $finish;
    end
  end

  function automatic logic [1:0] pick_format();
    return ($urandom_range(0, 11) == 0) ? FMT_UNKNOWN : 2'($urandom_range(0, 2));
  endfunction

  // One input transaction, at times preceded by an idle gap when a burst runs out.
  task automatic send_char(input logic [7:0] ch, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_char_byte <= ch;
    in_last      <= lst;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tags_due != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_format(input logic [1:0] fmt);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fmt;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_fmt = fmt;
  endtask

  // Builds a line that walks the format's script, then breaks about three in eight of them.
  task automatic make_line(input logic [1:0] fmt);
    step_t      st;
    int         idx;
    int         n;
    logic [7:0] ch;
    bit         ended;
    line_q.delete();
    ended = 1'b0;
    for (idx = 0; idx < 32 && !ended; idx++) begin
      st = get_step(fmt, 5'(idx));
      if (!st.valid) begin
        ended = 1'b1;
      end else begin
        case (st.kind)
          K_COLLECT: begin
            n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 7);
            repeat (n) begin
              do ch = 8'($urandom_range(0, 255)); while (ch == st.arg);
              line_q.push_back(ch);
            end
            line_q.push_back(st.arg);
          end
          K_SKIP: repeat (st.arg) line_q.push_back(8'($urandom_range(0, 255)));
          K_REST: begin
            repeat ($urandom_range(0, 8)) line_q.push_back(8'($urandom_range(0, 255)));
            ended = 1'b1;
          end
          default: begin
            repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(0, 255)));
            ended = 1'b1;
          end
        endcase
      end
    end
    n = $urandom_range(0, 7);
    if (line_q.size() == 0) n = 2;
    case (n)
      0: if (line_q.size() > 1) begin
        idx = $urandom_range(1, line_q.size() - 1);
        while (line_q.size() > idx) void'(line_q.pop_back());
      end
      1: line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
      2: begin
        line_q.delete();
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 4))
            0:       ch = CH_SPACE;
            1:       ch = CH_RBRACK;
            2:       ch = CH_QUOTE;
            3:       ch = CH_T;
            default: ch = 8'($urandom_range(0, 255));
          endcase
          line_q.push_back(ch);
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    int    i;
    int    switch_at;
    int    phase_lines;
    string line_txt;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = FMT_COMMON;
    in_valid     = 1'b0;
    in_char_byte = 8'h00;
    in_last      = 1'b0;
    cur_fmt      = FMT_COMMON;
    burst_left   = 0;
    items_sent   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Host cut off by the end of the line, then a line of only the space that ends an empty host.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(CH_SPACE, 1'b1);

    // A well-formed error log line, including the scan for 't' that tags no field.
    write_format(FMT_ERROR);
    line_txt = "[] [] []xt ] m";
    for (i = 0; i < line_txt.len(); i++)
      send_char(line_txt[i], i == line_txt.len() - 1);

    // Format switched in the middle of a line.
    send_char("[", 1'b0);
    write_format(FMT_COMMON);
    send_char("a", 1'b1);

    write_format(FMT_UNKNOWN);
    send_char("q", 1'b0);
    send_char(8'h80, 1'b1);

    items_sent  = 0;
    phase_lines = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase_lines == 0) begin
        write_format(pick_format());
        phase_lines = $urandom_range(2, 8);
      end
      phase_lines--;
      make_line(cur_fmt);
      switch_at = -1;
      if ($urandom_range(0, 7) == 0 && line_q.size() > 1)
        switch_at = $urandom_range(1, line_q.size() - 1);
      for (i = 0; i < line_q.size(); i++) begin
        if (i == switch_at) write_format(pick_format());
        send_char(line_q[i], i == line_q.size() - 1);
      end
      if ($urandom_range(0, 15) == 0) drain();
    end

    drain();
    repeat (4) @(negedge clk);
    if (tag_errors == 0 && tags_due == 0)
      $display("web_log_line_field_splitter_core verification clean");
    else
      $display("web_log_line_field_splitter_core verification failed");
    $finish;
  end

endmodule
